### rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Shared field widths, operation codes and status codes for the linked list
// engine.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

### rtl/sll_ram.sv
// ----------------------------------------------------------------------------
// sll_ram
// Simple dual-port synchronous memory: one write port, one read port with a
// registered read. Read data holds when not reading.
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/static_linked_list_engine_core.sv
// Sequencing: a rejected transaction goes from idle to the result state and on to the
//   output register; an insert or delete walks from the list head, the pointer walk
//   reading one next link per cycle from the single-read-port link memory.
// Throughput: one transaction at a time, the next accepted the cycle after the
//   result has moved to the output register.
// Reset: a clearing pass over every link memory slot relinks the free list, in_stall high.
// ----------------------------------------------------------------------------
// static_linked_list_engine_core
// Array-backed singly linked list with a free list of slots, held in a link
// memory and a data memory, driven by a pointer-walking sequencer.
// ----------------------------------------------------------------------------
module static_linked_list_engine_core #(
  parameter int NODE_COUNT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [sll_pkg::POS_W-1:0]         in_position,
  input  logic signed [sll_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sll_pkg::STAT_W-1:0]        out_status,
  output logic signed [sll_pkg::VAL_W-1:0]  out_removed_value,
  output logic [sll_pkg::POS_W-1:0]         out_list_length
);

  import sll_pkg::*;

  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam int AW = $clog2(NODE_COUNT);
  localparam int EW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] LAST_SLOT = LW'(NODE_COUNT);
  localparam logic [AW-1:0] LAST_IDX  = AW'(NODE_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_FREE,
    S_WALK,
    S_LINK,
    S_INS_PRED,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [LW-1:0]       free_head_r, free_head_nxt;
  logic [LW-1:0]       list_head_r, list_head_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic                op_r, op_nxt;
  logic [POS_W-1:0]    rem_r, rem_nxt;
  logic [LW-1:0]       prev_r, prev_nxt;
  logic [LW-1:0]       cur_r, cur_nxt;
  logic [LW-1:0]       new_free_r, new_free_nxt;
  logic                rd_zero_r, rd_zero_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [VAL_W-1:0]    res_removed_r, res_removed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_removed_r, out_removed_nxt;
  logic [POS_W-1:0]    out_len_r, out_len_nxt;

  logic                lnk_we, lnk_re;
  logic [AW-1:0]       lnk_waddr;
  logic [LW-1:0]       lnk_wdata, lnk_rd_data, lnk_rd_link, rd_slot;
  logic                dat_we, dat_re;
  logic [AW-1:0]       dat_waddr;
  logic [VAL_W-1:0]    dat_rd_data;

  logic                bad_ins, bad_del;

  function automatic logic [AW-1:0] slot_idx(input logic [LW-1:0] slot);
    logic [LW-1:0] t;
    t = slot - LW'(1);
    return t[AW-1:0];
  endfunction

  // a link read from slot 0, or one that points beyond the last slot, counts as none
  assign lnk_rd_link = (rd_zero_r || (lnk_rd_data > LAST_SLOT)) ? '0 : lnk_rd_data;

  assign bad_ins = (in_position == '0) ||
                   (EW'(in_position) > (EW'(cnt_r) + EW'(1)));
  assign bad_del = (in_position == '0) || (EW'(in_position) > EW'(cnt_r));

  sll_ram #(.DEPTH(NODE_COUNT), .WIDTH(LW)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .re    (lnk_re),
    .raddr (slot_idx(rd_slot)),
    .rdata (lnk_rd_data)
  );

  sll_ram #(.DEPTH(NODE_COUNT), .WIDTH(VAL_W)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (in_value),
    .re    (dat_re),
    .raddr (slot_idx(cur_r)),
    .rdata (dat_rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    free_head_nxt   = free_head_r;
    list_head_nxt   = list_head_r;
    cnt_nxt         = cnt_r;
    op_nxt          = op_r;
    rem_nxt         = rem_r;
    prev_nxt        = prev_r;
    cur_nxt         = cur_r;
    new_free_nxt    = new_free_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_len_nxt     = out_len_r;
    lnk_we    = 1'b0;
    lnk_waddr = '0;
    lnk_wdata = '0;
    lnk_re    = 1'b0;
    rd_slot   = '0;
    dat_we    = 1'b0;
    dat_waddr = slot_idx(free_head_r);
    dat_re    = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        lnk_we    = 1'b1;
        lnk_waddr = clr_idx_r;
        lnk_wdata = (clr_idx_r == LAST_IDX) ? '0 : (LW'(clr_idx_r) + LW'(2));
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_operation;
          res_status_nxt  = STAT_DONE;
          res_removed_nxt = '0;
          prev_nxt        = '0;
          cur_nxt         = list_head_r;
          rem_nxt         = in_position - POS_W'(1);
          if (in_operation == OP_INSERT) begin
            if (bad_ins) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = S_RESULT;
            end else if ((free_head_r == '0) || (free_head_r > LAST_SLOT)) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_RESULT;
            end else begin
              lnk_re    = 1'b1;
              rd_slot   = free_head_r;
              dat_we    = 1'b1;
              state_nxt = S_INS_FREE;
            end
          end else begin
            if (bad_del) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = S_RESULT;
            end else if (in_position == POS_W'(1)) begin
              state_nxt = S_LINK;
            end else begin
              lnk_re    = 1'b1;
              rd_slot   = list_head_r;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_INS_FREE: begin
        new_free_nxt = lnk_rd_link;
        if (rem_r == '0) begin
          state_nxt = S_LINK;
        end else begin
          lnk_re    = 1'b1;
          rd_slot   = cur_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // one link per cycle: the returned link addresses the next read
        prev_nxt = cur_r;
        cur_nxt  = lnk_rd_link;
        rem_nxt  = rem_r - POS_W'(1);
        if (rem_r == POS_W'(1)) begin
          state_nxt = S_LINK;
        end else begin
          lnk_re  = 1'b1;
          rd_slot = lnk_rd_link;
        end
      end
      S_LINK: begin
        if (op_r == OP_INSERT) begin
          lnk_we    = 1'b1;
          lnk_waddr = slot_idx(free_head_r);
          lnk_wdata = cur_r;
          if (prev_r == '0) begin
            list_head_nxt = free_head_r;
            free_head_nxt = new_free_r;
            cnt_nxt       = cnt_r + LW'(1);
            state_nxt     = S_RESULT;
          end else begin
            state_nxt = S_INS_PRED;
          end
        end else if (cur_r == '0) begin
          res_status_nxt = STAT_RANGE;
          state_nxt      = S_RESULT;
        end else begin
          lnk_re    = 1'b1;
          rd_slot   = cur_r;
          dat_re    = 1'b1;
          state_nxt = S_DEL_UNLINK;
        end
      end
      S_INS_PRED: begin
        lnk_we        = 1'b1;
        lnk_waddr     = slot_idx(prev_r);
        lnk_wdata     = free_head_r;
        free_head_nxt = new_free_r;
        cnt_nxt       = cnt_r + LW'(1);
        state_nxt     = S_RESULT;
      end
      S_DEL_UNLINK: begin
        res_removed_nxt = dat_rd_data;
        if (prev_r == '0) begin
          list_head_nxt = lnk_rd_link;
        end else begin
          lnk_we    = 1'b1;
          lnk_waddr = slot_idx(prev_r);
          lnk_wdata = lnk_rd_link;
        end
        state_nxt = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        // freed slot goes back on top of the free list
        lnk_we        = 1'b1;
        lnk_waddr     = slot_idx(cur_r);
        lnk_wdata     = free_head_r;
        free_head_nxt = cur_r;
        cnt_nxt       = cnt_r - LW'(1);
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = res_removed_r;
          out_len_nxt     = POS_W'(cnt_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    rd_zero_nxt = lnk_re ? (rd_slot == '0) : rd_zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      free_head_r <= LW'(1);
      list_head_r <= '0;
      cnt_r       <= '0;
      rd_zero_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      free_head_r   <= free_head_nxt;
      list_head_r   <= list_head_nxt;
      cnt_r         <= cnt_nxt;
      rd_zero_r     <= rd_zero_nxt;
      out_valid_r   <= out_valid_nxt;
      op_r          <= op_nxt;
      rem_r         <= rem_nxt;
      prev_r        <= prev_nxt;
      cur_r         <= cur_nxt;
      new_free_r    <= new_free_nxt;
      res_status_r  <= res_status_nxt;
      res_removed_r <= res_removed_nxt;
      out_status_r  <= out_status_nxt;
      out_removed_r <= out_removed_nxt;
      out_len_r     <= out_len_nxt;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_list_length   = out_len_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_SLOT)
    else $error("entry count above slot count");

  a_empty_free_full: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == '0) |-> (cnt_r == LAST_SLOT))
    else $error("free list empty while list not full");

  a_full_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == LAST_SLOT) |-> (free_head_r == '0))
    else $error("slot leaked: list full but free list not empty");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !lnk_we)
    else $error("link memory written while idle");
`endif

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the static linked list engine. A behavioural copy
// of the list and its free list predicts every transaction result; directed
// edge cases, a fill-to-full pass and randomised insert/delete traffic run
// under several idle and back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import sll_pkg::*;

  localparam int NODE_COUNT = 64;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  removed;
    logic [POS_W-1:0]  length;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_operation;
  logic [POS_W-1:0]         in_position;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic signed [VAL_W-1:0]  out_removed_value;
  logic [POS_W-1:0]         out_list_length;

  // shadow copy of the list, slots 1..NODE_COUNT, link 0 means none
  int unsigned      link_mem [NODE_COUNT+1];
  logic [VAL_W-1:0] data_mem [NODE_COUNT+1];
  int unsigned      free_head;
  int unsigned      list_head;
  int unsigned      entry_count;

  list_result_t pending_results[$];
  int           error_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  static_linked_list_engine_core #(
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_list_length  (out_list_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic void reset_list_model();
    for (int s = 0; s <= NODE_COUNT; s++) begin
      link_mem[s] = (s >= 1 && s < NODE_COUNT) ? s + 1 : 0;
      data_mem[s] = '0;
    end
    free_head   = 1;
    list_head   = 0;
    entry_count = 0;
  endfunction

  function automatic int unsigned follow_link(int unsigned s);
    if (s == 0 || s > NODE_COUNT) return 0;
    return (link_mem[s] > NODE_COUNT) ? 0 : link_mem[s];
  endfunction

  function automatic int unsigned slot_at(int unsigned pos);
    int unsigned s;
    s = list_head;
    for (int unsigned i = 1; i < pos && s != 0; i++) s = follow_link(s);
    return s;
  endfunction

  function automatic list_result_t apply_list_op(logic op, int unsigned pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  s;
    int unsigned  p;
    int unsigned  d;
    r.status  = STAT_DONE;
    r.removed = '0;
    if (op == OP_INSERT) begin
      if (pos < 1 || pos > entry_count + 1) begin
        r.status = STAT_RANGE;
      end else if (free_head == 0 || free_head > NODE_COUNT) begin
        r.status = STAT_FULL;
      end else begin
        s           = free_head;
        free_head   = follow_link(s);
        data_mem[s] = val;
        p = (pos == 1) ? 0 : slot_at(pos - 1);
        if (p == 0) begin
          link_mem[s] = list_head;
          list_head   = s;
        end else begin
          link_mem[s] = follow_link(p);
          link_mem[p] = s;
        end
        entry_count++;
      end
    end else begin
      if (pos < 1 || pos > entry_count) begin
        r.status = STAT_RANGE;
      end else begin
        if (pos == 1) begin
          d         = list_head;
          list_head = follow_link(d);
        end else begin
          p = slot_at(pos - 1);
          d = follow_link(p);
          if (p != 0) link_mem[p] = follow_link(d);
        end
        if (d != 0) begin
          r.removed   = data_mem[d];
          link_mem[d] = free_head;
          free_head   = d;
          entry_count--;
        end else begin
          r.status = STAT_RANGE;
        end
      end
    end
    r.length = POS_W'(entry_count);
    return r;
  endfunction

  task automatic send_item(logic op, int unsigned pos, logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= POS_W'(pos);
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_list_op(op, pos, val));
    @(negedge clk);
  endtask

  // called on a falling edge; holds the sender off until the block is empty
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, longint exp_v, longint act_v);
    error_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
  endtask

  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    list_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, list_length", -1, out_list_length);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status)
          report_mismatch("status", exp_r.status, out_status);
        if (out_removed_value !== exp_r.removed)
          report_mismatch("removed_value", $signed(exp_r.removed), out_removed_value);
        if (out_list_length !== exp_r.length)
          report_mismatch("list_length", exp_r.length, out_list_length);
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_DELETE, 1, 32'h0);            // empty list
    send_item(OP_INSERT, 0, 32'h1234_5678);    // position zero
    send_item(OP_INSERT, 2, 32'h1234_5678);    // beyond end of empty list
    send_item(OP_INSERT, 1, 32'h7fff_ffff);
    send_item(OP_INSERT, 2, 32'h8000_0000);    // append
    send_item(OP_INSERT, 2, 32'hffff_ffff);    // middle
    send_item(OP_INSERT, 1, 32'h0000_0000);    // new head
    send_item(OP_INSERT, 5, 32'h5555_5555);
    send_item(OP_INSERT, 127, 32'haaaa_aaaa);  // all position bits set
    send_item(OP_INSERT, 64, 32'haaaa_aaaa);
    send_item(OP_DELETE, 127, 32'h0);
    send_item(OP_DELETE, 0, 32'h0);
    send_item(OP_DELETE, 6, 32'h0);            // one past the end
    send_item(OP_DELETE, 3, 32'hdead_beef);    // value ignored on delete
    send_item(OP_DELETE, 4, 32'h0);            // tail
    send_item(OP_DELETE, 1, 32'h0);            // head
    send_item(OP_INSERT, 3, 32'haaaa_aaaa);
    send_item(OP_DELETE, 2, 32'h0);
    send_item(OP_DELETE, 1, 32'h0);
    send_item(OP_DELETE, 1, 32'h0);
    send_item(OP_DELETE, 1, 32'h0);            // empty again
    wait_for_results();
  endtask

  task automatic test_full_list();
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    while (entry_count < NODE_COUNT)
      send_item(OP_INSERT, $urandom_range(1, entry_count + 1), pick_value());
    send_item(OP_INSERT, entry_count + 1, 32'h0);  // no free slot
    send_item(OP_INSERT, 1, 32'hffff_ffff);
    send_item(OP_INSERT, entry_count + 2, 32'h0);  // range wins over full
    send_item(OP_DELETE, entry_count + 1, 32'h0);
    send_item(OP_DELETE, entry_count, 32'h0);
    send_item(OP_INSERT, entry_count + 1, 32'h7fff_ffff);
    // drain in random order so the free list ends up scrambled
    while (entry_count > 0)
      send_item(OP_DELETE, $urandom_range(1, entry_count), 32'h0);
    send_item(OP_DELETE, 1, 32'h0);
    wait_for_results();
  endtask

  task automatic test_random_ops(int count, int idle_pct, int stall_pct, int insert_pct);
    logic        op;
    int unsigned pos;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: any operation at any encodable position
        op  = logic'($urandom_range(0, 1));
        pos = $urandom_range(0, 127);
      end else begin
        op = (entry_count == 0 || $urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
        if (op == OP_INSERT) pos = $urandom_range(1, entry_count + 1);
        else                 pos = $urandom_range(1, entry_count);
      end
      send_item(op, pos, pick_value());
    end
    wait_for_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_INSERT;
    in_position    = '0;
    in_value       = '0;
    out_stall      = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reset_list_model();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_list();
    test_random_ops(80, 0, 0, 60);
    test_random_ops(80, 68, 0, 50);
    test_random_ops(80, 0, 68, 70);
    test_random_ops(80, 29, 29, 35);

    wait_for_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/sll_pkg.sv
rtl/sll_ram.sv
rtl/static_linked_list_engine_core.sv
dv/tb_top.sv
